// File: hdl/slot_admission_limiter_top_assert.svh
// ----------------------------------------------------------------------------
// Slot admission limiter assertion macros
// Shared property wrappers for the limiter's port checker.
// ----------------------------------------------------------------------------
`ifndef SLOT_ADMISSION_LIMITER_TOP_ASSERT_SVH
`define SLOT_ADMISSION_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot admission limiter check failed");

// Next-cycle implication, disabled during reset.
`define SAL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot admission limiter check failed");

`endif

// File: hdl/sal_pkg.sv
// ----------------------------------------------------------------------------
// Slot admission limiter package
// Shared types, command and status codes, and field widths.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;
    localparam int PCT_W    = 7;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 120;

    // Threshold arithmetic: product of max and percent, then a divide by 100
    // done as a multiply by a scaled reciprocal.
    localparam int PROD_W       = 12;
    localparam int THR_W        = 6;
    localparam int DIV100_MUL_W = 13;
    localparam int DIV100_SHIFT = 19;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STATS   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT   = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_APPLY
    } state_t;

endpackage

// File: hdl/slot_admission_limiter_top.sv
// ----------------------------------------------------------------------------
// Slot admission limiter
// Holds a set of active IDs and admits, releases and queries them against a
// configurable limit, with watermark events and saturating statistics.
// ----------------------------------------------------------------------------
// Usage: a command transaction enters on the s_ channel and exactly one result
// transaction leaves on the m_ channel. The block takes one command at a time.
// After acceptance, the ID store is scanned one entry per cycle through a
// single registered read port and a single comparator. The result is
// registered as the block leaves its apply state, and the block is ready
// again from that same cycle on.
// The result sits in an output register; the next command is accepted while
// it still waits. If the receiver stalls, the following command finishes its
// scan and then waits before updating any state until the output register
// is free. Configuration writes on cfg_we/cfg_index/cfg_data take effect at
// once and must only be made while the block is idle.
// Reset empties the set, clears all counters and the watermark flag, and
// loads max_slots 10, high mark 80 percent and low mark 50 percent.
// ----------------------------------------------------------------------------
module slot_admission_limiter_top #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata fields from bit 0: command[2:0], publisher_id[31:0], zero pad.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sal_pkg::IN_DATA_W-1:0]       s_tdata,
    // m_tdata fields from bit 0: status[2:0], is_member, high_mark_event,
    // low_mark_event, active_count[4:0], remaining_slots[4:0],
    // peak_count[4:0], acquire_total[31:0], release_total[31:0],
    // reject_total[31:0], zero pad.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sal_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sal_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int KEY_W = (ID_BITS < sal_pkg::ID_W) ? ID_BITS : sal_pkg::ID_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MUL_W = sal_pkg::PROD_W + sal_pkg::DIV100_MUL_W;
    localparam int CAP_LIM_I = (CAPACITY > 31) ? 31 : CAPACITY;
    localparam logic [sal_pkg::CNT_W-1:0] CAP_LIM = sal_pkg::CNT_W'(CAP_LIM_I);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [sal_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

    sal_pkg::state_t state_reg, state_next;

    logic [KEY_W-1:0]             id_mem [CAPACITY];
    logic [KEY_W-1:0]             rdata_reg;
    logic                         mem_we;

    logic [IDX_W-1:0]             addr_reg, addr_next;
    logic                         cmp_vld_reg;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic [KEY_W-1:0]             key_reg;
    logic [sal_pkg::CMD_W-1:0]    cmd_reg;

    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             found_idx_reg, found_idx_next;
    logic                         free_ok_reg, free_ok_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;

    logic [CAPACITY-1:0]          valid_reg, valid_next;
    logic [sal_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sal_pkg::CNT_W-1:0]    peak_reg, peak_next;
    logic [sal_pkg::TOTAL_W-1:0]  acq_reg, acq_next;
    logic [sal_pkg::TOTAL_W-1:0]  rel_reg, rel_next;
    logic [sal_pkg::TOTAL_W-1:0]  rej_reg, rej_next;
    logic                         armed_reg, armed_next;

    logic                         m_valid_reg, m_valid_next;
    logic [sal_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         member_reg, member_next;
    logic                         hi_reg, hi_next;
    logic                         lo_reg, lo_next;

    logic [sal_pkg::CNT_W-1:0]    max_slots_reg;
    logic [sal_pkg::PCT_W-1:0]    high_pct_reg;
    logic [sal_pkg::PCT_W-1:0]    low_pct_reg;
    logic [sal_pkg::PROD_W-1:0]   high_prod_reg, low_prod_reg;
    logic [sal_pkg::THR_W-1:0]    high_thr_reg, low_thr_reg;
    logic [MUL_W-1:0]             high_mul, low_mul;

    logic [sal_pkg::CNT_W-1:0]    max_nz;
    logic [sal_pkg::CNT_W-1:0]    emax;
    logic [sal_pkg::CNT_W-1:0]    remaining;
    logic                         hit;

    logic                         mark_en;
    logic [sal_pkg::THR_W-1:0]    mark_prev, mark_cur;
    logic                         arm_mid;

    function automatic logic [sal_pkg::TOTAL_W-1:0] sat_inc(
        input logic [sal_pkg::TOTAL_W-1:0] v
    );
        return (v == TOTAL_MAX) ? v : v + sal_pkg::TOTAL_W'(1);
    endfunction

    // Effective limit and watermark thresholds.
    assign max_nz = (max_slots_reg == '0) ? sal_pkg::CNT_W'(1) : max_slots_reg;
    assign emax   = (max_nz > CAP_LIM) ? CAP_LIM : max_nz;
    assign remaining = (emax > count_reg) ? emax - count_reg : '0;

    assign high_mul = MUL_W'(high_prod_reg) * MUL_W'(sal_pkg::DIV100_MUL);
    assign low_mul  = MUL_W'(low_prod_reg) * MUL_W'(sal_pkg::DIV100_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg <= sal_pkg::CNT_W'(10);
            high_pct_reg  <= sal_pkg::PCT_W'(80);
            low_pct_reg   <= sal_pkg::PCT_W'(50);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sal_pkg::CFG_MAX_SLOTS: max_slots_reg <= cfg_data[sal_pkg::CNT_W-1:0];
                sal_pkg::CFG_HIGH_PCT:  high_pct_reg  <= cfg_data;
                sal_pkg::CFG_LOW_PCT:   low_pct_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        high_prod_reg <= sal_pkg::PROD_W'(emax) * sal_pkg::PROD_W'(high_pct_reg);
        low_prod_reg  <= sal_pkg::PROD_W'(emax) * sal_pkg::PROD_W'(low_pct_reg);
        high_thr_reg  <= high_mul[sal_pkg::DIV100_SHIFT +: sal_pkg::THR_W];
        low_thr_reg   <= low_mul[sal_pkg::DIV100_SHIFT +: sal_pkg::THR_W];
    end

    // ID store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[free_idx_reg] <= key_reg;
        end
        rdata_reg <= id_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= addr_reg;
        if (s_tvalid && s_tready)
        begin
            key_reg <= s_tdata[sal_pkg::CMD_W +: KEY_W];
            cmd_reg <= s_tdata[sal_pkg::CMD_W-1:0];
        end
    end

    assign hit = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rdata_reg == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sal_pkg::FSM_IDLE;
            addr_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            free_ok_reg   <= 1'b0;
            free_idx_reg  <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            acq_reg       <= '0;
            rel_reg       <= '0;
            rej_reg       <= '0;
            armed_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            status_reg    <= '0;
            member_reg    <= 1'b0;
            hi_reg        <= 1'b0;
            lo_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cmp_vld_reg   <= (state_reg == sal_pkg::FSM_SCAN);
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
            free_ok_reg   <= free_ok_next;
            free_idx_reg  <= free_idx_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            acq_reg       <= acq_next;
            rel_reg       <= rel_next;
            rej_reg       <= rej_next;
            armed_reg     <= armed_next;
            m_valid_reg   <= m_valid_next;
            status_reg    <= status_next;
            member_reg    <= member_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        acq_next       = acq_reg;
        rel_next       = rel_reg;
        rej_next       = rej_reg;
        armed_next     = armed_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        status_next    = status_reg;
        member_next    = member_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        mem_we         = 1'b0;
        mark_en        = 1'b0;
        mark_prev      = '0;
        mark_cur       = '0;
        arm_mid        = armed_reg;

        // Compare stage runs in the cycle after the read address.
        if (hit && !found_reg)
        begin
            found_next     = 1'b1;
            found_idx_next = cmp_idx_reg;
        end
        if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_ok_reg)
        begin
            free_ok_next  = 1'b1;
            free_idx_next = cmp_idx_reg;
        end

        case (state_reg)
            sal_pkg::FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next   = sal_pkg::FSM_SCAN;
                    addr_next    = '0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                end
            end
            sal_pkg::FSM_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                begin
                    state_next = sal_pkg::FSM_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            sal_pkg::FSM_DRAIN:
            begin
                state_next = sal_pkg::FSM_APPLY;
            end
            sal_pkg::FSM_APPLY:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next   = sal_pkg::FSM_IDLE;
                    m_valid_next = 1'b1;
                    hi_next      = 1'b0;
                    lo_next      = 1'b0;
                    member_next  = found_reg;
                    status_next  = sal_pkg::ST_DONE;
                    case (cmd_reg)
                        sal_pkg::CMD_ACQUIRE:
                        begin
                            if (found_reg)
                            begin
                                status_next = sal_pkg::ST_HELD;
                            end
                            else if (count_reg >= emax)
                            begin
                                rej_next    = sat_inc(rej_reg);
                                status_next = sal_pkg::ST_REJECTED;
                            end
                            else
                            begin
                                valid_next[free_idx_reg] = 1'b1;
                                mem_we      = 1'b1;
                                count_next  = count_reg + sal_pkg::CNT_W'(1);
                                acq_next    = sat_inc(acq_reg);
                                if (count_next > peak_reg)
                                begin
                                    peak_next = count_next;
                                end
                                mark_en     = 1'b1;
                                member_next = 1'b1;
                                status_next = sal_pkg::ST_OK;
                            end
                        end
                        sal_pkg::CMD_RELEASE:
                        begin
                            member_next = 1'b0;
                            if (found_reg)
                            begin
                                valid_next[found_idx_reg] = 1'b0;
                                count_next  = count_reg - sal_pkg::CNT_W'(1);
                                rel_next    = sat_inc(rel_reg);
                                mark_en     = 1'b1;
                                status_next = sal_pkg::ST_OK;
                            end
                            else
                            begin
                                status_next = sal_pkg::ST_NOT_FOUND;
                            end
                        end
                        sal_pkg::CMD_QUERY:
                        begin
                            status_next = found_reg ? sal_pkg::ST_OK : sal_pkg::ST_NOT_FOUND;
                        end
                        sal_pkg::CMD_CLEAR:
                        begin
                            valid_next  = '0;
                            count_next  = '0;
                            armed_next  = 1'b0;
                            member_next = 1'b0;
                        end
                        sal_pkg::CMD_STATS:
                        begin
                            peak_next = count_reg;
                            acq_next  = '0;
                            rel_next  = '0;
                            rej_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    // Hysteresis: the high check goes first, the low check sees its result.
                    if (mark_en)
                    begin
                        mark_prev = {1'b0, count_reg};
                        mark_cur  = {1'b0, count_next};
                        hi_next   = !armed_reg && (mark_cur >= high_thr_reg)
                                    && (mark_prev < high_thr_reg);
                        arm_mid   = armed_reg || hi_next;
                        lo_next   = arm_mid && (mark_cur <= low_thr_reg)
                                    && (mark_prev > low_thr_reg);
                        armed_next = arm_mid && !lo_next;
                    end
                end
            end
            default:
            begin
                state_next = sal_pkg::FSM_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == sal_pkg::FSM_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, rej_reg, rel_reg, acq_reg, peak_reg, remaining, count_reg,
                       lo_reg, hi_reg, member_reg, status_reg};

endmodule

// File: hdl/sal_checker.sv
// ----------------------------------------------------------------------------
// Slot admission limiter port checker
// Watches the limiter's channels and checks result consistency over time.
// ----------------------------------------------------------------------------
`include "slot_admission_limiter_top_assert.svh"

module sal_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sal_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [sal_pkg::STATUS_W-1:0] status;
    logic                         is_member;
    logic                         any_event;
    logic [sal_pkg::CNT_W-1:0]    active_count;
    logic [sal_pkg::CNT_W-1:0]    peak_count;

    assign status       = m_tdata[2:0];
    assign is_member    = m_tdata[3];
    assign any_event    = m_tdata[4] || m_tdata[5];
    assign active_count = m_tdata[10:6];
    assign peak_count   = m_tdata[20:16];

    // A stalled result transaction holds its payload.
    `SAL_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One command transaction at a time: the scan keeps the input closed.
    `SAL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // Watermark events only come from a successful acquire or release.
    `SAL_ASSERT_NOW(a_event_on_ok, m_tvalid && any_event, status == sal_pkg::ST_OK)

    // An acquire that finds the ID held leaves it a member.
    `SAL_ASSERT_NOW(a_held_is_member, m_tvalid && (status == sal_pkg::ST_HELD), is_member)

    // The peak never trails the active count.
    `SAL_ASSERT_NOW(a_peak_covers_count, m_tvalid, peak_count >= active_count)

endmodule

bind slot_admission_limiter_top sal_checker u_sal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
